FILE: sv/transformed_box_bounds_macros.svh
// Assertion helpers for the property checker in the sv directory (tbb_props).
`ifndef TRANSFORMED_BOX_BOUNDS_MACROS_SVH
`define TRANSFORMED_BOX_BOUNDS_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define TBB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("transformed_box_bounds check failed");

// Next-cycle implication, quiet during reset.
`define TBB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("transformed_box_bounds check failed");

// Next-cycle implication that also watches reset itself.
`define TBB_ASSERT_NEXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("transformed_box_bounds check failed");

`endif

FILE: sv/tbb_pkg.sv
`default_nettype none

package tbb_pkg;

  localparam int DATA_W         = 32;
  localparam int FRAC_BITS      = 16;
  localparam int COORD_BITS_DEF = 32;
  // Sum of three floored products and one entry stays below 2^49.
  localparam int SUM_W          = 50;
  // Quotient bits kept by the divider; anything larger saturates.
  localparam int Q_BITS         = 33;
  localparam int OVF_SHIFT      = Q_BITS - FRAC_BITS;
  localparam int NUM_REGS       = 6;
  localparam int IDX_W          = 3;
  localparam int NUM_ENTRIES    = 16;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [IDX_W-1:0] REG_MIN_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_MIN_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_MIN_Z = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAX_X = 3'd3;
  localparam logic [IDX_W-1:0] REG_MAX_Y = 3'd4;
  localparam logic [IDX_W-1:0] REG_MAX_Z = 3'd5;

  localparam logic       OP_COLUMN = 1'b0;
  localparam logic       OP_BASE   = 1'b1;
  localparam logic [1:0] LAST_COL  = 2'd3;

  // One queued job: column-major matrix, entry index is {column, row}.
  typedef struct packed {
    logic                                op;
    logic                                restart;
    logic                                last;
    logic [NUM_ENTRIES-1:0][DATA_W-1:0]  m;
  } job_t;

endpackage

`default_nettype wire

FILE: sv/tbb_in_if.sv
`default_nettype none

interface tbb_in_if;
  logic                                valid;
  logic                                ready;
  logic                                opcode;
  logic [1:0]                          column;
  logic signed [tbb_pkg::DATA_W-1:0]   entry_row0;
  logic signed [tbb_pkg::DATA_W-1:0]   entry_row1;
  logic signed [tbb_pkg::DATA_W-1:0]   entry_row2;
  logic signed [tbb_pkg::DATA_W-1:0]   entry_row3;
  logic                                restart;

  modport source (output valid, opcode, column, entry_row0, entry_row1, entry_row2,
                  entry_row3, restart, input ready);
  modport sink (input valid, opcode, column, entry_row0, entry_row1, entry_row2,
                entry_row3, restart, output ready);
endinterface

`default_nettype wire

FILE: sv/tbb_out_if.sv
`default_nettype none

interface tbb_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tbb_pkg::DATA_W-1:0]   box_min_x;
  logic signed [tbb_pkg::DATA_W-1:0]   box_min_y;
  logic signed [tbb_pkg::DATA_W-1:0]   box_min_z;
  logic signed [tbb_pkg::DATA_W-1:0]   box_max_x;
  logic signed [tbb_pkg::DATA_W-1:0]   box_max_y;
  logic signed [tbb_pkg::DATA_W-1:0]   box_max_z;
  logic                                box_valid;

  modport source (output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                  box_max_z, box_valid, input ready);
  modport sink (input valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                box_max_z, box_valid, output ready);
endinterface

`default_nettype wire

FILE: sv/tbb_front.sv
`default_nettype none

module tbb_front (
  input  logic           clk,
  tbb_in_if.sink         in_ch,
  input  logic           full,
  output logic           push,
  output tbb_pkg::job_t  push_job
);

  logic [11:0][tbb_pkg::DATA_W-1:0] held;
  logic [3:0][tbb_pkg::DATA_W-1:0]  entries;
  logic                             accept;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign entries     = {in_ch.entry_row3, in_ch.entry_row2, in_ch.entry_row1,
                        in_ch.entry_row0};

  // Columns 0..2 are held here; base includes, column 3 and restarts go into the queue.
  assign push = accept && ((in_ch.opcode == tbb_pkg::OP_BASE) ||
                           (in_ch.column == tbb_pkg::LAST_COL) || in_ch.restart);

  always_ff @(posedge clk) begin
    if (accept && (in_ch.opcode == tbb_pkg::OP_COLUMN) &&
        (in_ch.column != tbb_pkg::LAST_COL)) begin
      for (int r = 0; r < 4; r++) begin
        held[{in_ch.column, 2'(r)}] <= entries[r];
      end
    end
  end

  always_comb begin
    push_job.op      = in_ch.opcode;
    push_job.restart = in_ch.restart;
    push_job.last    = (in_ch.column == tbb_pkg::LAST_COL);
    for (int i = 0; i < 12; i++) begin
      push_job.m[i] = held[i];
    end
    for (int r = 0; r < 4; r++) begin
      push_job.m[12 + r] = entries[r];
    end
  end

endmodule

`default_nettype wire

FILE: sv/tbb_queue.sv
`default_nettype none

module tbb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tbb_pkg::job_t  push_job,
  output logic           full,
  input  logic           pop,
  output tbb_pkg::job_t  pop_job,
  output logic           empty
);

  localparam int PTR_W = $clog2(tbb_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(tbb_pkg::QUEUE_DEPTH + 1);

  tbb_pkg::job_t     slots [tbb_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [CNT_W-1:0]  count;

  assign full    = (count == CNT_W'(tbb_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_job = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_W'(tbb_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PTR_W'(tbb_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/tbb_back.sv
`default_nettype none

module tbb_back #(
  parameter int COORD_BITS = tbb_pkg::COORD_BITS_DEF
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  logic                                                   empty,
  input  tbb_pkg::job_t                                          pop_job,
  output logic                                                   pop,
  input  logic [tbb_pkg::NUM_REGS-1:0][tbb_pkg::DATA_W-1:0]      base,
  tbb_out_if.source                                              out_ch
);

  localparam int DW    = tbb_pkg::DATA_W;
  localparam int SW    = tbb_pkg::SUM_W;
  localparam int QB    = tbb_pkg::Q_BITS;
  localparam int SAT_W = (COORD_BITS < DW) ? COORD_BITS : DW;
  localparam int CNT_W = $clog2(QB);

  localparam logic signed [SW-1:0]    HI_W = SW'((64'sd1 <<< (SAT_W - 1)) - 64'sd1);
  localparam logic signed [SW-1:0]    LO_W = SW'(-HI_W - 1);
  localparam logic signed [SAT_W-1:0] HI_S = SAT_W'(HI_W);
  localparam logic signed [SAT_W-1:0] LO_S = SAT_W'(LO_W);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BASE = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DSET = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_INC  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  function automatic logic signed [SAT_W-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SAT_W-1:0] res;
    if (v > HI_W) begin
      res = HI_S;
    end else if (v < LO_W) begin
      res = LO_S;
    end else begin
      res = SAT_W'(v);
    end
    return res;
  endfunction

  logic [2:0]               state;
  tbb_pkg::job_t            job;
  logic [2:0]               corner;
  logic [1:0]               k;
  logic [CNT_W-1:0]         cnt;
  logic signed [2*DW-1:0]   prod [4];
  logic signed [SW-1:0]     sum [4];
  logic [SW-1:0]            rem [3];
  logic [QB-1:0]            dsh [3];
  logic [QB-1:0]            quo [3];
  logic [2:0]               neg;
  logic [2:0]               ovf;
  logic [SW-1:0]            ub;
  logic                     wzero;
  logic signed [SAT_W-1:0]  acc_min [3];
  logic signed [SAT_W-1:0]  acc_max [3];
  logic                     acc_valid;
  logic                     out_valid;
  logic signed [DW-1:0]     o_min [3];
  logic signed [DW-1:0]     o_max [3];
  logic                     o_valid;

  logic signed [SAT_W-1:0]  base_s [tbb_pkg::NUM_REGS];
  logic signed [SAT_W-1:0]  coord [3];
  logic signed [SAT_W-1:0]  csel;
  logic [SW-1:0]            ub_next;
  logic signed [SAT_W-1:0]  pa [3];
  logic signed [SAT_W-1:0]  pb [3];
  logic signed [SAT_W-1:0]  pt [3];
  logic signed [SW-1:0]     qv [3];
  logic                     out_free;

  assign pop      = (state == S_IDLE) && !empty;
  assign out_free = !out_valid || out_ch.ready;

  always_comb begin
    for (int i = 0; i < tbb_pkg::NUM_REGS; i++) begin
      base_s[i] = sat(SW'($signed(base[i])));
    end
    coord[0] = corner[2] ? base_s[tbb_pkg::REG_MAX_X] : base_s[tbb_pkg::REG_MIN_X];
    coord[1] = corner[1] ? base_s[tbb_pkg::REG_MAX_Y] : base_s[tbb_pkg::REG_MIN_Y];
    coord[2] = corner[0] ? base_s[tbb_pkg::REG_MAX_Z] : base_s[tbb_pkg::REG_MIN_Z];
    unique case (k)
      2'd0:    csel = coord[0];
      2'd1:    csel = coord[1];
      default: csel = coord[2];
    endcase
    ub_next = sum[3][SW-1] ? SW'(-sum[3]) : SW'(sum[3]);
  end

  // Corner point after the divide, or the two base points.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      qv[r] = $signed(SW'(quo[r]));
      if (wzero) begin
        pt[r] = sat(sum[r]);
      end else if (ovf[r]) begin
        pt[r] = neg[r] ? LO_S : HI_S;
      end else begin
        pt[r] = sat(neg[r] ? -qv[r] : qv[r]);
      end
      if (state == S_BASE) begin
        pa[r] = base_s[r];
        pb[r] = base_s[3 + r];
      end else begin
        pa[r] = pt[r];
        pb[r] = pt[r];
      end
    end
  end

  // Datapath: multiply-accumulate and one quotient bit per cycle on three lanes.
  always_ff @(posedge clk) begin
    logic signed [SW-1:0]  ua;
    logic [SW+15:0]        dvd;
    logic [SW:0]           t;
    if (pop) begin
      job <= pop_job;
    end
    if (state == S_MUL) begin
      for (int r = 0; r < 4; r++) begin
        if (k != tbb_pkg::LAST_COL) begin
          prod[r] <= $signed(job.m[{k, 2'(r)}]) * $signed(DW'(csel));
        end
        if (k == 2'd0) begin
          sum[r] <= SW'($signed(job.m[{tbb_pkg::LAST_COL, 2'(r)}]));
        end else begin
          sum[r] <= sum[r] + SW'(prod[r] >>> tbb_pkg::FRAC_BITS);
        end
      end
    end
    if (state == S_DSET) begin
      ub    <= ub_next;
      wzero <= (sum[3] == '0);
      for (int r = 0; r < 3; r++) begin
        ua     = sum[r][SW-1] ? -sum[r] : sum[r];
        dvd    = {ua, tbb_pkg::FRAC_BITS'(0)};
        rem[r] <= SW'(dvd[SW+15:QB]);
        dsh[r] <= dvd[QB-1:0];
        ovf[r] <= {tbb_pkg::OVF_SHIFT'(0), ua} >= {ub_next, tbb_pkg::OVF_SHIFT'(0)};
        neg[r] <= sum[r][SW-1] ^ sum[3][SW-1];
      end
    end
    if (state == S_DIV) begin
      for (int r = 0; r < 3; r++) begin
        t = {rem[r], dsh[r][QB-1]};
        if (t >= {1'b0, ub}) begin
          rem[r] <= SW'(t - {1'b0, ub});
          quo[r] <= {quo[r][QB-2:0], 1'b1};
        end else begin
          rem[r] <= SW'(t);
          quo[r] <= {quo[r][QB-2:0], 1'b0};
        end
        dsh[r] <= {dsh[r][QB-2:0], 1'b0};
      end
    end
    if ((state == S_DONE) && out_free) begin
      for (int r = 0; r < 3; r++) begin
        o_min[r] <= DW'(acc_min[r]);
        o_max[r] <= DW'(acc_max[r]);
      end
      o_valid <= acc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      corner    <= '0;
      k         <= '0;
      cnt       <= '0;
      acc_valid <= 1'b0;
      out_valid <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        acc_min[r] <= HI_S;
        acc_max[r] <= LO_S;
      end
    end else begin
      if ((state == S_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            if (pop_job.restart) begin
              acc_valid <= 1'b0;
              for (int r = 0; r < 3; r++) begin
                acc_min[r] <= HI_S;
                acc_max[r] <= LO_S;
              end
            end
            corner <= '0;
            k      <= '0;
            // Restart-only jobs carry a column below the last; finish here.
            if (pop_job.op == tbb_pkg::OP_BASE) begin
              state <= S_BASE;
            end else if (pop_job.last) begin
              state <= S_MUL;
            end
          end
        end
        S_BASE, S_INC: begin
          acc_valid <= 1'b1;
          for (int r = 0; r < 3; r++) begin
            if ((pa[r] < acc_min[r]) || (pb[r] < acc_min[r])) begin
              acc_min[r] <= (pa[r] < pb[r]) ? pa[r] : pb[r];
            end
            if ((pa[r] > acc_max[r]) || (pb[r] > acc_max[r])) begin
              acc_max[r] <= (pa[r] > pb[r]) ? pa[r] : pb[r];
            end
          end
          if ((state == S_BASE) || (corner == 3'd7)) begin
            state <= S_DONE;
          end else begin
            corner <= corner + 1'b1;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          k <= k + 1'b1;
          if (k == tbb_pkg::LAST_COL) begin
            state <= S_DSET;
          end
        end
        S_DSET: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(QB - 1)) begin
            state <= S_INC;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.box_min_x = o_min[0];
  assign out_ch.box_min_y = o_min[1];
  assign out_ch.box_min_z = o_min[2];
  assign out_ch.box_max_x = o_max[0];
  assign out_ch.box_max_y = o_max[1];
  assign out_ch.box_max_z = o_max[2];
  assign out_ch.box_valid = o_valid;

endmodule

`default_nettype wire

FILE: sv/transformed_box_bounds.sv
// Channel   Dir  Payload
// in_ch     in   opcode, column, entry_row0..3, restart
// out_ch    out  box_min_x/y/z, box_max_x/y/z, box_valid
// cfg_*     in   cfg_wen, cfg_index, cfg_data (base box registers)
//
// Columns 0..2 without restart are held in the front end and skip the queue.
// Base include: the back end steps through its base and done states; column 3:
// 8 corners, each with a multiply-accumulate over the four columns and the
// 33-step divider on three lanes. A two-entry queue decouples the front from the
// back; out_ch holds its result while stalled and the back waits in its done state.
// rst is synchronous and clears the box, the queue and the base registers.
`default_nettype none

module transformed_box_bounds #(
  parameter int COORD_BITS = tbb_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  tbb_in_if.sink                        in_ch,
  tbb_out_if.source                     out_ch,
  input  logic                          cfg_wen,
  input  logic [tbb_pkg::IDX_W-1:0]     cfg_index,
  input  logic [tbb_pkg::DATA_W-1:0]    cfg_data
);

  logic [tbb_pkg::NUM_REGS-1:0][tbb_pkg::DATA_W-1:0] base;
  logic           push;
  logic           full;
  logic           pop;
  logic           empty;
  tbb_pkg::job_t  push_job;
  tbb_pkg::job_t  pop_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
    end else if (cfg_wen && (cfg_index < tbb_pkg::IDX_W'(tbb_pkg::NUM_REGS))) begin
      base[cfg_index] <= cfg_data;
    end
  end

  tbb_front u_front (
    .clk      (clk),
    .in_ch    (in_ch),
    .full     (full),
    .push     (push),
    .push_job (push_job)
  );

  tbb_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  tbb_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .empty   (empty),
    .pop_job (pop_job),
    .pop     (pop),
    .base    (base),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

FILE: sv/tbb_checker.sv
`default_nettype none
`include "transformed_box_bounds_macros.svh"

module tbb_props (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               box_valid,
  input logic signed [tbb_pkg::DATA_W-1:0]  box_min_x,
  input logic signed [tbb_pkg::DATA_W-1:0]  box_max_x
);

  `TBB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `TBB_ASSERT_NOW(a_box_valid, out_valid, box_valid)
  `TBB_ASSERT_NOW(a_box_order, out_valid, box_min_x <= box_max_x)
  `TBB_ASSERT_NEXT_RST(a_reset, rst, in_ready && !out_valid)

endmodule

bind transformed_box_bounds tbb_props u_tbb_props (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .box_valid (out_ch.box_valid),
  .box_min_x (out_ch.box_min_x),
  .box_max_x (out_ch.box_max_x)
);

`default_nettype wire

FILE: test/tbb_checker.sv
`default_nettype none

module tbb_checker (
  input  logic                      clk,
  input  logic                      rst,
  tbb_in_if                         req_ch,
  tbb_out_if                        box_ch,
  input  logic                      cfg_wen,
  input  logic [tbb_pkg::IDX_W-1:0] cfg_index,
  input  logic [tbb_pkg::DATA_W-1:0] cfg_data,
  output int                        fails,
  output int                        pending,
  output int                        boxes_seen
);
  import tbb_pkg::*;

  localparam longint CO_HI = 64'sd2147483647;
  localparam longint CO_LO = -CO_HI - 1;

  typedef struct packed {
    logic [2:0][DATA_W-1:0] lo;
    logic [2:0][DATA_W-1:0] hi;
    logic                   v;
  } bounds_t;

  bounds_t bounds_due[$];
  longint  base_box[NUM_REGS];
  longint  held[12];
  longint  run_lo[3];
  longint  run_hi[3];
  bit      run_v;

  initial begin
    fails      = 0;
    pending    = 0;
    boxes_seen = 0;
  end

  function automatic longint clamp(longint v);
    if (v > CO_HI) return CO_HI;
    if (v < CO_LO) return CO_LO;
    return v;
  endfunction

  // quotient a * 2^16 / b, truncated toward zero, saturated
  function automatic longint div_fix(longint a, longint b);
    bit         neg;
    bit [127:0] ua;
    bit [127:0] ub;
    bit [127:0] mag;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    mag = (ua << FRAC_BITS) / ub;
    if (neg && mag >= 128'h80000000) return CO_LO;
    if (!neg && mag > 128'h7fffffff) return CO_HI;
    return neg ? -longint'(mag[62:0]) : longint'(mag[62:0]);
  endfunction

  function automatic void clear_box();
    for (int i = 0; i < 3; i++) begin
      run_lo[i] = CO_HI;
      run_hi[i] = CO_LO;
    end
    run_v = 0;
  endfunction

  function automatic void widen(longint p0, longint p1, longint p2);
    longint p[3];
    p = '{p0, p1, p2};
    for (int i = 0; i < 3; i++) begin
      if (p[i] < run_lo[i]) run_lo[i] = p[i];
      if (p[i] > run_hi[i]) run_hi[i] = p[i];
    end
    run_v = 1;
  endfunction

  function automatic void predict_box();
    longint  m[16];
    longint  c[3];
    longint  s[4];
    longint  p[3];
    bounds_t b;
    if (req_ch.restart) clear_box();
    if (req_ch.opcode == OP_BASE) begin
      widen(clamp(base_box[REG_MIN_X]), clamp(base_box[REG_MIN_Y]), clamp(base_box[REG_MIN_Z]));
      widen(clamp(base_box[REG_MAX_X]), clamp(base_box[REG_MAX_Y]), clamp(base_box[REG_MAX_Z]));
    end else if (req_ch.column != LAST_COL) begin
      held[req_ch.column*4 + 0] = longint'(req_ch.entry_row0);
      held[req_ch.column*4 + 1] = longint'(req_ch.entry_row1);
      held[req_ch.column*4 + 2] = longint'(req_ch.entry_row2);
      held[req_ch.column*4 + 3] = longint'(req_ch.entry_row3);
      return;
    end else begin
      for (int i = 0; i < 12; i++) m[i] = held[i];
      m[12] = longint'(req_ch.entry_row0);
      m[13] = longint'(req_ch.entry_row1);
      m[14] = longint'(req_ch.entry_row2);
      m[15] = longint'(req_ch.entry_row3);
      for (int k = 0; k < 8; k++) begin
        c[0] = clamp(base_box[k[2] ? REG_MAX_X : REG_MIN_X]);
        c[1] = clamp(base_box[k[1] ? REG_MAX_Y : REG_MIN_Y]);
        c[2] = clamp(base_box[k[0] ? REG_MAX_Z : REG_MIN_Z]);
        // arithmetic shift floors each product
        for (int r = 0; r < 4; r++)
          s[r] = ((m[r] * c[0]) >>> FRAC_BITS) + ((m[4+r] * c[1]) >>> FRAC_BITS)
               + ((m[8+r] * c[2]) >>> FRAC_BITS) + m[12+r];
        for (int r = 0; r < 3; r++)
          p[r] = (s[3] != 0) ? div_fix(s[r], s[3]) : clamp(s[r]);
        widen(p[0], p[1], p[2]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      b.lo[i] = run_lo[i][31:0];
      b.hi[i] = run_hi[i][31:0];
    end
    b.v = run_v;
    bounds_due.push_back(b);
  endfunction

  task automatic check_box();
    bounds_t    want;
    bounds_t    got;
    string      nm[6];
    logic [31:0] w;
    logic [31:0] g;
    nm = '{"box_min_x", "box_min_y", "box_min_z", "box_max_x", "box_max_y", "box_max_z"};
    got.lo = {box_ch.box_min_z, box_ch.box_min_y, box_ch.box_min_x};
    got.hi = {box_ch.box_max_z, box_ch.box_max_y, box_ch.box_max_x};
    got.v  = box_ch.box_valid;
    boxes_seen++;
    if (bounds_due.size() == 0) begin
      $error("unexpected result: box_min_x %0d box_valid %0d", $signed(got.lo[0]), got.v);
      fails++;
      return;
    end
    want = bounds_due.pop_front();
    for (int i = 0; i < 6; i++) begin
      w = (i < 3) ? want.lo[i] : want.hi[i-3];
      g = (i < 3) ? got.lo[i] : got.hi[i-3];
      if (w !== g) begin
        $error("%s expected %0d actual %0d", nm[i], $signed(w), $signed(g));
        fails++;
      end
    end
    if (want.v !== got.v) begin
      $error("box_valid expected %0d actual %0d", want.v, got.v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) base_box[i] = 0;
      for (int i = 0; i < 12; i++) held[i] = 0;
      clear_box();
      bounds_due.delete();
    end else begin
      if (cfg_wen && cfg_index < NUM_REGS) base_box[cfg_index] = longint'($signed(cfg_data));
      if (box_ch.valid && box_ch.ready) check_box();
      if (req_ch.valid && req_ch.ready) predict_box();
    end
    pending <= bounds_due.size();
  end
endmodule

`default_nettype wire

FILE: test/tb_transformed_box_bounds.sv
`default_nettype none

module tb_transformed_box_bounds;
  import tbb_pkg::*;

  localparam int ITEMS     = 1500;
  localparam int SETTLE    = 400;
  localparam int LONG_HOLD = 3000;

  logic              clk;
  logic              rst;
  logic              cfg_wen;
  logic [IDX_W-1:0]  cfg_index;
  logic [DATA_W-1:0] cfg_data;
  logic              req_took;
  bit                calm;
  bit                long_req;
  bit                long_done;
  int                fails;
  int                pending;
  int                boxes_seen;
  int                sent;

  tbb_in_if  in_ch ();
  tbb_out_if out_ch ();

  transformed_box_bounds DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tbb_checker u_checker (
    .clk(clk), .rst(rst), .req_ch(in_ch), .box_ch(out_ch),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending), .boxes_seen(boxes_seen)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("tb_transformed_box_bounds failed");
    $finish;
  end

  always @(posedge clk) req_took <= in_ch.valid && in_ch.ready;

  // receiver: random stalls, one long hold-off, none near the end
  initial begin
    out_ch.ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (calm) begin
        out_ch.ready = 1;
        @(negedge clk);
      end else if (long_req && !long_done) begin
        out_ch.ready = 0;
        repeat (LONG_HOLD) @(negedge clk);
        long_done = 1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ch.ready = 0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end else begin
        out_ch.ready = 1;
        repeat ($urandom_range(1, 40)) @(negedge clk);
      end
    end
  end

  function automatic logic [31:0] pick_entry();
    logic [31:0] odd[6];
    odd = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h1, 32'hffffffff, 32'h00010000};
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      1: return $urandom;
      2: return odd[$urandom_range(0, 5)];
      3: return 32'h0;
      default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  task automatic send_req(logic op, logic [1:0] col, logic [31:0] r0, logic [31:0] r1,
                          logic [31:0] r2, logic [31:0] r3, logic clr);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid = 0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_ch.valid      = 1;
    in_ch.opcode     = op;
    in_ch.column     = col;
    in_ch.entry_row0 = r0;
    in_ch.entry_row1 = r1;
    in_ch.entry_row2 = r2;
    in_ch.entry_row3 = r3;
    in_ch.restart    = clr;
    do @(negedge clk); while (!req_took);
    sent++;
  endtask

  // one instance matrix; w row style: 0 affine, 1 perspective, 2 w zero
  task automatic send_matrix(int style, bit clr);
    logic [31:0] w;
    for (int k = 0; k < 4; k++) begin
      if (style == 1) w = pick_entry();
      else if (style == 0 && k == 3) w = 32'h0001_0000;
      else w = 32'h0;
      send_req(OP_COLUMN, 2'(k), pick_entry(), pick_entry(), pick_entry(), w,
               clr && k == 0);
    end
  endtask

  task automatic write_box(logic [31:0] v[NUM_REGS]);
    logic [IDX_W-1:0] regs[NUM_REGS];
    regs = '{REG_MIN_X, REG_MIN_Y, REG_MIN_Z, REG_MAX_X, REG_MAX_Y, REG_MAX_Z};
    in_ch.valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_wen   = 1;
      cfg_index = regs[i];
      cfg_data  = v[i];
      @(negedge clk);
    end
    cfg_wen = 0;
  endtask

  task automatic small_box();
    logic [31:0] v[NUM_REGS];
    for (int i = 0; i < NUM_REGS; i++)
      v[i] = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    write_box(v);
  endtask

  initial begin
    logic [31:0] v[NUM_REGS];
    int          phase;
    int          n;
    rst         = 1;
    calm        = 0;
    long_req    = 0;
    long_done   = 0;
    sent        = 0;
    cfg_wen     = 0;
    cfg_index   = REG_MIN_X;
    cfg_data    = 0;
    in_ch.valid = 0;
    in_ch.opcode = OP_COLUMN;
    in_ch.column = 2'd0;
    in_ch.entry_row0 = 0;
    in_ch.entry_row1 = 0;
    in_ch.entry_row2 = 0;
    in_ch.entry_row3 = 0;
    in_ch.restart = 0;
    repeat (7) @(negedge clk);
    rst = 0;

    // directed: box from (-1,-2,-3) to (1,2,3), identity-like matrices, base points, edge values
    write_box('{32'hffff_0000, 32'hfffe_0000, 32'hfffd_0000,
                32'h0001_0000, 32'h0002_0000, 32'h0003_0000});
    send_req(OP_BASE, 2'd3, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    send_req(OP_COLUMN, 2'd0, 32'h0001_0000, 0, 0, 0, 1'b0);
    send_req(OP_COLUMN, 2'd1, 0, 32'h0001_0000, 0, 0, 1'b0);
    send_req(OP_COLUMN, 2'd2, 0, 0, 32'h0001_0000, 0, 1'b0);
    send_req(OP_COLUMN, 2'd3, 32'h0005_8000, 32'hfffc_0000, 0, 32'h0001_0000, 1'b1);
    send_req(OP_COLUMN, 2'd3, 0, 0, 0, 0, 1'b1);
    send_req(OP_COLUMN, 2'd3, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h1, 1'b1);
    send_req(OP_COLUMN, 2'd3, 32'h80000000, 32'h7fffffff, 32'h0, 32'hffffffff, 1'b0);
    send_req(OP_COLUMN, 2'd0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0);
    send_req(OP_COLUMN, 2'd1, 32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h7fffffff, 1'b1);
    send_req(OP_COLUMN, 2'd2, 32'hffffffff, 32'h1, 32'h80000000, 32'h0, 1'b0);
    send_req(OP_COLUMN, 2'd3, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h0002_0000, 1'b0);
    send_req(OP_BASE, 2'd0, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1);
    write_box('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
    send_req(OP_BASE, 2'd1, 0, 0, 0, 0, 1'b1);
    send_req(OP_COLUMN, 2'd3, 32'h0001_0000, 0, 0, 32'h0001_0000, 1'b0);
    write_box('{32'h80000000, 32'h80000000, 32'h80000000,
                32'h80000000, 32'h80000000, 32'h80000000});
    send_req(OP_BASE, 2'd2, 0, 0, 0, 0, 1'b0);
    send_req(OP_COLUMN, 2'd3, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
    write_box('{32'h7fffffff, 32'h80000000, 32'h7fffffff,
                32'h80000000, 32'h7fffffff, 32'h80000000});
    send_req(OP_BASE, 2'd0, 0, 0, 0, 0, 1'b1);
    send_req(OP_COLUMN, 2'd3, 32'h0000_8000, 32'hffff_8000, 32'h1, 32'h0, 1'b0);

    // random: mostly whole matrices, some stray columns and base includes
    phase = 0;
    while (sent < ITEMS) begin
      case (phase % 4)
        0: small_box();
        1: begin
          for (int i = 0; i < NUM_REGS; i++) v[i] = $urandom;
          write_box(v);
        end
        default: small_box();
      endcase
      if (phase == 1) long_req = 1;
      if (sent > ITEMS * 85 / 100) calm = 1;
      n = sent + 150;
      while (sent < n && sent < ITEMS) begin
        case ($urandom_range(0, 9))
          0, 1: send_req(OP_BASE, 2'($urandom), $urandom, $urandom, $urandom, $urandom,
                         $urandom_range(0, 4) == 0);
          2: send_req(OP_COLUMN, 2'($urandom_range(0, 2)), pick_entry(), pick_entry(),
                      pick_entry(), pick_entry(), $urandom_range(0, 4) == 0);
          3: send_req(OP_COLUMN, LAST_COL, pick_entry(), pick_entry(), pick_entry(),
                      pick_entry(), $urandom_range(0, 4) == 0);
          default: send_matrix($urandom_range(0, 2), $urandom_range(0, 3) == 0);
        endcase
      end
      phase++;
    end

    in_ch.valid = 0;
    calm = 1;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    $display("Sent %0d requests over %0d base box settings; checked %0d bounds results.",
             sent, phase + 4, boxes_seen);
    if (fails == 0) $display("tb_transformed_box_bounds passed");
    else $display("tb_transformed_box_bounds failed");
    $finish;
  end
endmodule

`default_nettype wire
